/* hdl/mqtt_keepalive_rx_engine_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the keep-alive receive engine
// Shared forms of the concurrent checks used at the top level.
// ---------------------------------------------------------------------------
`ifndef MQTT_KEEPALIVE_RX_ENGINE_DEFINES_SVH
`define MQTT_KEEPALIVE_RX_ENGINE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define KAR_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("check failed");

// Consequent must hold in the cycle after the antecedent
`define KAR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* hdl/kar_pkg.sv */
// ---------------------------------------------------------------------------
// kar_pkg
// Types, codes and constants shared by the keep-alive receive engine.
// ---------------------------------------------------------------------------
package kar_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_IDLE    = 3'd0,
    KIND_TX      = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_TIMEOUT = 3'd3,
    KIND_LENERR  = 3'd4
  } kind_t;

  // Deframer phase
  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2
  } phase_t;

  // Register indexes (address bit 2)
  localparam logic REG_KEEP_ALIVE = 1'b0;
  localparam logic REG_BUF_SIZE   = 1'b1;

  localparam int          CFG_AW        = 3;
  localparam int          LIMIT_W       = 26;
  localparam int          MS_PER_S      = 1000;
  localparam logic [15:0] KEEP_RST      = 16'd15;
  localparam logic [15:0] BUF_RST       = 16'd256;
  localparam logic [26:0] AGE_MAX       = 27'h7FF_FFFF;
  localparam logic [2:0]  LEN_BYTES_MAX = 3'd4;

  localparam logic [3:0] PT_PINGREQ  = 4'd12;
  localparam logic [3:0] PT_PINGRESP = 4'd13;
  localparam logic [7:0] TX_PINGREQ  = 8'hC0;
  localparam logic [7:0] TX_PINGRESP = 8'hD0;
  localparam logic [7:0] TX_ZERO     = 8'h00;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Configuration seen by the core
  typedef struct packed {
    logic [LIMIT_W-1:0] limit_ms;
    logic [15:0]        buffer_size;
  } cfg_t;

  // One result beat
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  tx_byte;
    logic [3:0]  packet_type;
    logic [27:0] remaining_length;
    logic [2:0]  length_bytes;
    logic [15:0] stored_length;
    logic        last;
  } res_t;

  // Result queue status
  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               room;
  } q_stat_t;

endpackage

/* hdl/kar_if.sv */
// ---------------------------------------------------------------------------
// kar_in_if / kar_out_if
// Valid/ready channels for input items and result beats.
// ---------------------------------------------------------------------------
interface kar_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  logic       link_up;

  modport source(output valid, func, rx_byte, link_up, input ready);
  modport sink(input valid, func, rx_byte, link_up, output ready);
endinterface

interface kar_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  tx_byte;
  logic [3:0]  packet_type;
  logic [27:0] remaining_length;
  logic [2:0]  length_bytes;
  logic [15:0] stored_length;
  logic        last;

  modport source(output valid, kind, tx_byte, packet_type, remaining_length,
                 length_bytes, stored_length, last, input ready);
  modport sink(input valid, kind, tx_byte, packet_type, remaining_length,
               length_bytes, stored_length, last, output ready);
endinterface

/* hdl/kar_cfg.sv */
// ---------------------------------------------------------------------------
// kar_cfg
// APB register file: keep-alive interval and buffer size, plus the
// keep-alive limit in milliseconds computed on each keep-alive write.
// ---------------------------------------------------------------------------
module kar_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kar_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output kar_pkg::cfg_t              cfg
);
  import kar_pkg::*;

  logic [15:0]        keep_r, keep_nxt;
  logic [15:0]        buf_r, buf_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode writes; scale seconds to milliseconds on the way in
  always_comb begin
    keep_nxt  = keep_r;
    buf_nxt   = buf_r;
    limit_nxt = limit_r;
    if (wr_en) begin
      case (paddr[2])
        REG_KEEP_ALIVE: begin
          keep_nxt  = pwdata[15:0];
          limit_nxt = LIMIT_W'(pwdata[15:0]) * LIMIT_W'(MS_PER_S);
        end
        REG_BUF_SIZE: buf_nxt = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r  <= KEEP_RST;
      buf_r   <= BUF_RST;
      limit_r <= LIMIT_W'(KEEP_RST) * LIMIT_W'(MS_PER_S);
    end else begin
      keep_r  <= keep_nxt;
      buf_r   <= buf_nxt;
      limit_r <= limit_nxt;
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_KEEP_ALIVE: prdata = {16'd0, keep_r};
      REG_BUF_SIZE:   prdata = {16'd0, buf_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.limit_ms    = limit_r;
  assign cfg.buffer_size = buf_r;

endmodule

/* hdl/kar_core.sv */
// ---------------------------------------------------------------------------
// kar_core
// Deframer and keep-alive timers: updates state for one accepted item and
// produces up to two result beats for the queue.
// ---------------------------------------------------------------------------
module kar_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          func,
  input  logic [7:0]    rx_byte,
  input  logic          link_up,
  input  kar_pkg::cfg_t cfg,
  output logic [1:0]    push_n,
  output kar_pkg::res_t res0,
  output kar_pkg::res_t res1
);
  import kar_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  header_r, header_nxt;
  logic [27:0] accum_r, accum_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [27:0] left_r, left_nxt;
  logic [15:0] stored_r, stored_nxt;
  logic [26:0] in_age_r, in_age_nxt;
  logic [26:0] out_age_r, out_age_nxt;
  logic        ping_r, ping_nxt;
  logic [27:0] len_part;
  logic        fin;

  function automatic res_t mk(kind_t k, logic [7:0] tx);
    res_t r;
    r         = '0;
    r.kind    = k;
    r.tx_byte = tx;
    return r;
  endfunction

  // Place the 7 length bits of this byte by its position
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    len_part = {21'd0, rx_byte[6:0]};
      2'd1:    len_part = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_part = {7'd0, rx_byte[6:0], 14'd0};
      default: len_part = {rx_byte[6:0], 21'd0};
    endcase
  end

  // Next state and result beats
  always_comb begin
    phase_nxt   = phase_r;
    header_nxt  = header_r;
    accum_nxt   = accum_r;
    cnt_nxt     = cnt_r;
    left_nxt    = left_r;
    stored_nxt  = stored_r;
    in_age_nxt  = in_age_r;
    out_age_nxt = out_age_r;
    ping_nxt    = ping_r;
    push_n      = 2'd0;
    res0        = '0;
    res1        = '0;
    fin         = 1'b0;

    if (acc) begin
      if (!link_up) phase_nxt = PH_TYPE;
      if (!func) begin
        // Tick: age both timers, check expiry while the link is up
        if (in_age_r != AGE_MAX) in_age_nxt = in_age_r + 27'd1;
        if (out_age_r != AGE_MAX) out_age_nxt = out_age_r + 27'd1;
        if (link_up && ((in_age_nxt > {1'b0, cfg.limit_ms}) ||
                        (out_age_nxt > {1'b0, cfg.limit_ms}))) begin
          if (ping_r) begin
            push_n = 2'd1;
            res0   = mk(KIND_TIMEOUT, TX_ZERO);
          end else begin
            push_n      = 2'd2;
            res0        = mk(KIND_TX, TX_PINGREQ);
            res1        = mk(KIND_TX, TX_ZERO);
            in_age_nxt  = '0;
            out_age_nxt = '0;
            ping_nxt    = 1'b1;
          end
        end
      end else if (link_up) begin
        case (phase_r)
          PH_TYPE: begin
            header_nxt = rx_byte;
            accum_nxt  = '0;
            cnt_nxt    = '0;
            left_nxt   = '0;
            stored_nxt = '0;
            phase_nxt  = PH_LEN;
          end
          PH_LEN: begin
            accum_nxt = accum_r | len_part;
            cnt_nxt   = cnt_r + 3'd1;
            if (rx_byte[7]) begin
              // Continuation past the fourth byte is malformed
              if (cnt_nxt >= LEN_BYTES_MAX) begin
                phase_nxt = PH_TYPE;
                push_n    = 2'd1;
                res0      = mk(KIND_LENERR, TX_ZERO);
              end
            end else begin
              stored_nxt = {13'd0, cnt_nxt} + 16'd1;
              if (accum_nxt == '0) begin
                fin = 1'b1;
              end else begin
                left_nxt  = accum_nxt;
                phase_nxt = PH_PAY;
              end
            end
          end
          PH_PAY: begin
            if (stored_r < cfg.buffer_size) stored_nxt = stored_r + 16'd1;
            if (left_r != '0) left_nxt = left_r - 28'd1;
            if (left_nxt == '0) fin = 1'b1;
          end
          default: phase_nxt = PH_TYPE;
        endcase
      end

      // Packet complete: answer PINGREQ, clear ping on PINGRESP
      if (fin) begin
        phase_nxt  = PH_TYPE;
        in_age_nxt = '0;
        if (header_r[7:4] == PT_PINGREQ) begin
          push_n      = 2'd2;
          res0        = mk(KIND_TX, TX_PINGRESP);
          res1        = mk(KIND_TX, TX_ZERO);
          out_age_nxt = '0;
        end else begin
          if (header_r[7:4] == PT_PINGRESP) ping_nxt = 1'b0;
          push_n                = 2'd1;
          res0                  = mk(KIND_DONE, TX_ZERO);
          res0.packet_type      = header_r[7:4];
          res0.remaining_length = accum_nxt;
          res0.length_bytes     = cnt_nxt;
          res0.stored_length    = stored_nxt;
        end
      end

      // Flag the final beat of this item
      if (push_n == 2'd1) res0.last = 1'b1;
      if (push_n == 2'd2) res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TYPE;
      header_r  <= '0;
      accum_r   <= '0;
      cnt_r     <= '0;
      left_r    <= '0;
      stored_r  <= '0;
      in_age_r  <= '0;
      out_age_r <= '0;
      ping_r    <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      header_r  <= header_nxt;
      accum_r   <= accum_nxt;
      cnt_r     <= cnt_nxt;
      left_r    <= left_nxt;
      stored_r  <= stored_nxt;
      in_age_r  <= in_age_nxt;
      out_age_r <= out_age_nxt;
      ping_r    <= ping_nxt;
    end
  end

endmodule

/* hdl/kar_outq.sv */
// ---------------------------------------------------------------------------
// kar_outq
// Four-entry result queue: takes zero to two beats per cycle, hands out one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module kar_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  kar_pkg::res_t    res0,
  input  kar_pkg::res_t    res1,
  output kar_pkg::res_t    out_data,
  output logic             out_valid,
  input  logic             out_ready,
  output kar_pkg::q_stat_t stat
);
  import kar_pkg::*;

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid & out_ready;
  assign out_data  = mem_r[rd_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_nxt    = wr_r + FIFO_AW'(push_n);
    rd_nxt    = rd_r + FIFO_AW'(pop);
    count_nxt = count_r + FIFO_CW'(push_n) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  // Store beats
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= res0;
    if (push_n == 2'd2) mem_r[wr_r + FIFO_AW'(1)] <= res1;
  end

  // Room for two more beats regardless of the output side
  assign stat.count = count_r;
  assign stat.room  = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));

endmodule

/* hdl/mqtt_keepalive_rx_engine.sv */
// ---------------------------------------------------------------------------
// mqtt_keepalive_rx_engine
// Receive deframer and keep-alive timer of an MQTT client.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per received byte (func 1) or per 1 ms tick
//   (func 0), each with the current link_up flag. out_ch returns result beats:
//   bytes to transmit (PINGRESP D0 00, PINGREQ C0 00), packet completions,
//   keep-alive timeouts and length errors; last marks the final beat of an
//   input beat. The cfg_ APB port sets keep_alive_s and buffer_size; write it
//   only while the block is idle.
//   An input beat updates state at its accept edge, where its result beats
//   are also written into the result queue.
//   Throughput: one input beat per cycle while out_ch takes a beat per cycle;
//   beats producing two results are paced by the four-entry result queue,
//   which accepts input while it has room for two.
//   Reset: rst_n clears deframer state, timers, pending ping and the queue;
//   registers return to 15 s and 256 bytes.
//   Stall: while out_ch.ready is low beats collect in the queue and in_ch.ready
//   drops once fewer than two entries are free.
// ---------------------------------------------------------------------------
module mqtt_keepalive_rx_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  kar_in_if.sink                     in_ch,
  kar_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [kar_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import kar_pkg::*;

`include "mqtt_keepalive_rx_engine_defines.svh"

  cfg_t       cfg;
  q_stat_t    q_stat;
  res_t       res0, res1, out_data;
  logic [1:0] push_n;
  logic       in_acc;
  logic       out_pop;

  assign in_ch.ready = q_stat.room;
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign out_pop     = out_ch.valid & out_ch.ready;

  kar_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  kar_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .func    (in_ch.func),
    .rx_byte (in_ch.rx_byte),
    .link_up (in_ch.link_up),
    .cfg     (cfg),
    .push_n  (push_n),
    .res0    (res0),
    .res1    (res1)
  );

  kar_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1),
    .out_data  (out_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (q_stat)
  );

  // Drive result beat fields
  assign out_ch.kind             = 3'(out_data.kind);
  assign out_ch.tx_byte          = out_data.tx_byte;
  assign out_ch.packet_type      = out_data.packet_type;
  assign out_ch.remaining_length = out_data.remaining_length;
  assign out_ch.length_bytes     = out_data.length_bytes;
  assign out_ch.stored_length    = out_data.stored_length;
  assign out_ch.last             = out_data.last;

  // Completions, timeouts and length errors are always single beats
  `KAR_ASSERT_SAME(a_single_last, clk, rst_n, out_pop && (out_ch.kind != 3'(KIND_TX)), out_ch.last)
  // First byte of a ping pair is never the final beat
  `KAR_ASSERT_SAME(a_pair_first, clk, rst_n, out_pop && (out_ch.kind == 3'(KIND_TX)) && ((out_ch.tx_byte == TX_PINGREQ) || (out_ch.tx_byte == TX_PINGRESP)), !out_ch.last)
  // Queue never overfills
  `KAR_ASSERT_SAME(a_q_bound, clk, rst_n, 1'b1, q_stat.count <= FIFO_CW'(FIFO_DEPTH))
  // Pop with no accept drains exactly one entry
  `KAR_ASSERT_NEXT(a_q_drain, clk, rst_n, !in_acc && out_pop, q_stat.count == $past(q_stat.count) - FIFO_CW'(1))

endmodule
